@@ design/hsim_pkg.sv @@
// Shared types and constants for the hysteresis spike interval meter.
package hsim_pkg;

  // Field widths
  localparam int unsigned CH_W     = 4;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned THR_W    = 16;

  // Channel number widened so it can be compared against a channel count of up to 511
  localparam int unsigned CH_EXT_W = 9;

  // Default channel count
  localparam int unsigned CHANNELS_DEF = 16;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = ((CH_W + SAMPLE_W + TIME_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((CH_W + TIME_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_THR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THR = 1'b1;

  // Threshold reset values
  localparam logic signed [THR_W-1:0] UP_THR_RST   = 16'sd16384;
  localparam logic signed [THR_W-1:0] DOWN_THR_RST = 16'sd0;

  // Per-channel state as held in the state memory
  typedef struct packed {
    logic              spiking;
    logic [TIME_W-1:0] last_time;
  } chan_state_t;

  localparam int unsigned STATE_W = $bits(chan_state_t);

endpackage

@@ design/hsim_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hsim_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/hsim_rule.sv @@
// Schmitt-trigger update of one channel's state and interval computation.
module hsim_rule (
  input  hsim_pkg::chan_state_t                  cur_i,
  input  logic signed [hsim_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic        [hsim_pkg::TIME_W-1:0]     timestamp_i,
  input  logic signed [hsim_pkg::THR_W-1:0]      up_thr_i,
  input  logic signed [hsim_pkg::THR_W-1:0]      down_thr_i,
  output hsim_pkg::chan_state_t                  nxt_o,
  output logic                                   spike_o,
  output logic        [hsim_pkg::TIME_W-1:0]     interval_o
);
  import hsim_pkg::*;

  logic above;
  logic below;

  assign above = (sample_i > up_thr_i);
  assign below = (sample_i < down_thr_i);

  // Upper threshold wins over lower one
  assign spike_o = above && !cur_i.spiking;

  always_comb begin
    nxt_o = cur_i;
    if (above) begin
      nxt_o.spiking = 1'b1;
    end else if (below) begin
      nxt_o.spiking = 1'b0;
    end
    if (spike_o) begin
      nxt_o.last_time = timestamp_i;
    end
  end

  // Wraps modulo 2^32
  assign interval_o = timestamp_i - cur_i.last_time;

endmodule

@@ design/hysteresis_spike_interval_meter_core.sv @@
// Top level of the hysteresis spike interval meter.
//
// Samples arrive on the s_axis stream, one channel number, sample and
// timestamp per transfer. When a sample rises above the upper threshold on a
// channel that is not spiking, one result transfer on m_axis carries the
// channel and the ticks since that channel's previous spike (or since time
// zero). Other samples give no result.
// Throughput: one sample per cycle while the output register is free. A sample
// accepted on s_axis reads its channel entry from the state memory and is
// held and evaluated in the evaluate stage registers; once the output register
// is free the entry is written back and any result enters the output register,
// which drives m_axis_tvalid. Back-to-back samples on the same channel are
// served by a forwarding register around the memory.
// Reset clears the thresholds to their defaults and a per-channel valid
// vector, so every channel reads as not spiking with last time zero; no
// clearing pass is needed and samples are taken right after reset.
// A stalled receiver holds the output register; while it is full the sample
// in the evaluate stage waits, with or without a result, and s_axis_tready
// drops until the receiver takes the result.
// Thresholds are written through the cfg port; the user must write them only while idle, the block does not enforce it.
module hysteresis_spike_interval_meter_core #(
  parameter int unsigned CHANNELS = hsim_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [hsim_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hsim_pkg::THR_W-1:0]          cfg_wdata_i,
  // Sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: channel[3:0], sample[19:4], timestamp[51:20], zero pad
  input  logic [hsim_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: spike_channel[3:0], interval[35:4], zero pad
  output logic [hsim_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import hsim_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_EXT_W-1:0] CHANNELS_EXT = CH_EXT_W'(CHANNELS);

  // Thresholds
  logic signed [THR_W-1:0] up_thr_q;
  logic signed [THR_W-1:0] down_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_thr_q   <= UP_THR_RST;
      down_thr_q <= DOWN_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UP_THR:   up_thr_q   <= cfg_wdata_i;
        CFG_DOWN_THR: down_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input unpacking
  logic        [CH_W-1:0]     in_ch;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic        [TIME_W-1:0]   in_time;
  logic        [CH_EXT_W-1:0] in_ch_ext;
  logic        [IDX_W-1:0]    in_idx;
  logic                       in_in_range;
  logic                       in_xfer;

  assign in_ch       = s_axis_tdata[CH_W-1:0];
  assign in_sample   = s_axis_tdata[CH_W +: SAMPLE_W];
  assign in_time     = s_axis_tdata[CH_W+SAMPLE_W +: TIME_W];
  assign in_ch_ext   = CH_EXT_W'(in_ch);
  assign in_idx      = in_ch_ext[IDX_W-1:0];
  assign in_in_range = (in_ch_ext < CHANNELS_EXT);
  assign in_xfer     = s_axis_tvalid && s_axis_tready;

  // Evaluate stage registers
  logic                       s1_valid_q;
  logic        [CH_W-1:0]     s1_ch_q;
  logic        [IDX_W-1:0]    s1_idx_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic        [TIME_W-1:0]   s1_time_q;
  logic                       s1_in_range_q;
  logic                       fwd_hit_q;
  chan_state_t                fwd_data_q;

  // Channel entry valid bits
  logic [CHANNELS-1:0] ent_valid_q;

  // Output register
  logic              out_valid_q;
  logic [CH_W-1:0]   out_ch_q;
  logic [TIME_W-1:0] out_interval_q;

  logic              out_free;
  logic              s1_fire;
  logic              ram_we;
  logic [STATE_W-1:0] ram_rdata;
  chan_state_t       cur_state;
  chan_state_t       nxt_state;
  logic              rule_spike;
  logic              s1_spike;
  logic [TIME_W-1:0] rule_interval;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign ram_we        = s1_fire && s1_in_range_q;
  assign s1_spike      = s1_in_range_q && rule_spike;

  // State memory
  hsim_ram #(
    .WIDTH (STATE_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_idx_q),
    .wdata_i (nxt_state),
    .re_i    (in_xfer),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // Current entry: forwarded write, memory data, or reset value
  always_comb begin
    if (fwd_hit_q) begin
      cur_state = fwd_data_q;
    end else if (s1_in_range_q && ent_valid_q[s1_idx_q]) begin
      cur_state = chan_state_t'(ram_rdata);
    end else begin
      cur_state = '0;
    end
  end

  hsim_rule u_rule (
    .cur_i       (cur_state),
    .sample_i    (s1_sample_q),
    .timestamp_i (s1_time_q),
    .up_thr_i    (up_thr_q),
    .down_thr_i  (down_thr_q),
    .nxt_o       (nxt_state),
    .spike_o     (rule_spike),
    .interval_o  (rule_interval)
  );

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
      fwd_hit_q  <= ram_we && (s1_idx_q == in_idx);
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ch_q       <= in_ch;
      s1_idx_q      <= in_idx;
      s1_sample_q   <= in_sample;
      s1_time_q     <= in_time;
      s1_in_range_q <= in_in_range;
      fwd_data_q    <= nxt_state;
    end
  end

  // Valid bits set on first write of an entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else if (ram_we) begin
      ent_valid_q[s1_idx_q] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= s1_spike;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_spike) begin
      out_ch_q       <= s1_ch_q;
      out_interval_q <= rule_interval;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - CH_W - TIME_W){1'b0}}, out_interval_q, out_ch_q};

  // Checks
  a_spike_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_spike |=> m_axis_tvalid)
    else $error("spike did not reach the output register");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_fire))
    else $error("result appeared without a stage transfer");

  a_no_spike_when_spiking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_spike |-> !cur_state.spiking && nxt_state.spiking)
    else $error("spike on a channel already spiking");

  a_out_of_range_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_in_range_q |-> !ram_we && !s1_spike)
    else $error("out-of-range channel touched state");

  a_fwd_only_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !ram_we |=> !fwd_hit_q)
    else $error("forward hit without a preceding write");

endmodule

@@ dv/hysteresis_spike_interval_meter_core_tb.sv @@
// Self-checking testbench for the hysteresis spike interval meter core.
`timescale 1ns / 1ps

module hysteresis_spike_interval_meter_core_tb;
  import hsim_pkg::*;

  localparam int unsigned CHANNELS        = CHANNELS_DEF;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned DRAIN_CYCLES    = 8;    // idle time after the last result before a cfg write
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned PHASE_ITEMS     = 166;

  // One sample transfer, channel in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0]          timestamp;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]            channel;
  } sample_t;

  // One result transfer, spike channel in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0] interval;
    logic [CH_W-1:0]   spike_channel;
  } spike_t;

  // Directed rows: threshold write, sample with a typed result, sample with
  // no result, or sample checked against the predictor
  typedef enum logic [1:0] {ROW_CFG, ROW_SPIKE, ROW_QUIET, ROW_CHECKED} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CH_W-1:0]   channel;
    logic [15:0]       value;      // sample, or register data
    logic [TIME_W-1:0] timestamp;
    logic [TIME_W-1:0] interval;
  } row_t;

  // Where a random sample lands relative to the thresholds
  typedef enum int unsigned {
    LVL_ABOVE_UP, LVL_BELOW_DOWN, LVL_AT_UP, LVL_AT_DOWN, LVL_ANY
  } level_e;

  localparam row_t DIRECTED_ROWS [24] = '{
    // reset thresholds: up 16384, down 0
    '{ROW_QUIET,   CFG_UP_THR,   4'd0,  16'sd16384,  32'd100,        32'd0},
    '{ROW_SPIKE,   CFG_UP_THR,   4'd0,  16'sd16385,  32'd100,        32'd100},
    '{ROW_QUIET,   CFG_UP_THR,   4'd0,  16'sd32767,  32'd150,        32'd0},
    '{ROW_QUIET,   CFG_UP_THR,   4'd0,  16'sd0,      32'd160,        32'd0},
    '{ROW_QUIET,   CFG_UP_THR,   4'd0,  16'sd20000,  32'd170,        32'd0},
    '{ROW_QUIET,   CFG_UP_THR,   4'd0,  -16'sd1,     32'd180,        32'd0},
    '{ROW_SPIKE,   CFG_UP_THR,   4'd0,  16'sd32767,  32'd250,        32'd150},
    '{ROW_SPIKE,   CFG_UP_THR,   4'd15, 16'sd32767,  32'hFFFF_FFFF,  32'hFFFF_FFFF},
    '{ROW_QUIET,   CFG_UP_THR,   4'd15, 16'h8000,    32'd5,          32'd0},
    // earlier timestamp than the last spike: interval wraps
    '{ROW_SPIKE,   CFG_UP_THR,   4'd15, 16'sd16385,  32'd3,          32'd4},
    '{ROW_QUIET,   CFG_UP_THR,   4'd7,  16'h8000,    32'd0,          32'd0},
    '{ROW_SPIKE,   CFG_UP_THR,   4'd7,  16'sd30000,  32'd0,          32'd0},
    // back to back on one channel
    '{ROW_CHECKED, CFG_UP_THR,   4'd3,  16'sd20000,  32'd10,         32'd0},
    '{ROW_CHECKED, CFG_UP_THR,   4'd3,  -16'sd5,     32'd11,         32'd0},
    '{ROW_CHECKED, CFG_UP_THR,   4'd3,  16'sd20000,  32'd12,         32'd0},
    '{ROW_CHECKED, CFG_UP_THR,   4'd3,  16'sd20000,  32'd13,         32'd0},
    '{ROW_CHECKED, CFG_UP_THR,   4'd10, 16'h5A5A,    32'h8765_4321,  32'd0},
    // crossed thresholds: down above up
    '{ROW_CFG,     CFG_UP_THR,   4'd0,  -16'sd100,   32'd0,          32'd0},
    '{ROW_CFG,     CFG_DOWN_THR, 4'd0,  16'sd100,    32'd0,          32'd0},
    '{ROW_SPIKE,   CFG_UP_THR,   4'd2,  16'sd0,      32'd50,         32'd50},
    '{ROW_QUIET,   CFG_UP_THR,   4'd2,  16'sd0,      32'd60,         32'd0},
    '{ROW_QUIET,   CFG_UP_THR,   4'd2,  -16'sd200,   32'd70,         32'd0},
    '{ROW_QUIET,   CFG_UP_THR,   4'd2,  -16'sd100,   32'd80,         32'd0},
    '{ROW_SPIKE,   CFG_UP_THR,   4'd2,  -16'sd99,    32'd90,         32'd40}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [THR_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata: channel[3:0], sample[19:4], timestamp[51:20], zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // tdata: spike_channel[3:0], interval[35:4], zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor state
  logic signed [THR_W-1:0] up_thr_q;
  logic signed [THR_W-1:0] down_thr_q;
  bit                      spiking_q   [CHANNELS];
  logic [TIME_W-1:0]       last_time_q [CHANNELS];

  spike_t            expected_spikes [$];
  int unsigned       mismatches = 0;
  bit                gaps_on = 1'b1;
  bit                hold_off_req = 1'b0;
  logic [TIME_W-1:0] tick_q = '0;
  logic [CH_W-1:0]   prev_ch_q = '0;

  hysteresis_spike_interval_meter_core #(
    .CHANNELS (CHANNELS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Spike detection and interval for one sample; updates the channel state
  function automatic bit predict_spike(input sample_t s, output spike_t r);
    r = '0;
    if (s.channel >= CHANNELS) return 1'b0;
    if ($signed(s.sample) > up_thr_q) begin
      if (spiking_q[s.channel]) return 1'b0;
      spiking_q[s.channel]   = 1'b1;
      r.spike_channel        = s.channel;
      r.interval             = s.timestamp - last_time_q[s.channel];
      last_time_q[s.channel] = s.timestamp;
      return 1'b1;
    end
    if ($signed(s.sample) < down_thr_q) spiking_q[s.channel] = 1'b0;
    return 1'b0;
  endfunction

  // Random sample in the band that the level asks for; any level if empty
  function automatic logic [SAMPLE_W-1:0] pick_level(input level_e lvl);
    int up_lvl;
    int down_lvl;
    int lo;
    int hi;
    up_lvl   = up_thr_q;
    down_lvl = down_thr_q;
    lo = -32768;
    hi = 32767;
    case (lvl)
      LVL_ABOVE_UP:   lo = up_lvl + 1;
      LVL_BELOW_DOWN: hi = down_lvl - 1;
      LVL_AT_UP:      return up_thr_q;
      LVL_AT_DOWN:    return down_thr_q;
      default: ;
    endcase
    if (lo > hi) begin
      lo = -32768;
      hi = 32767;
    end
    return SAMPLE_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // Drop valid and wait until every result is in and the pipeline is empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_spikes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_UP_THR) up_thr_q = val;
    else if (idx == CFG_DOWN_THR) down_thr_q = val;
  endtask

  // Offer one sample and return at the edge where it transfers
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(s);
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
  endtask

  // Mostly rise/fall sequences per channel, with some noise and threshold hits
  task automatic send_random();
    sample_t     s;
    spike_t      r;
    int unsigned roll;
    if ($urandom_range(0, 9) < 3) s.channel = prev_ch_q;
    else s.channel = CH_W'($urandom_range(0, CHANNELS - 1));
    roll = $urandom_range(0, 99);
    if (roll < 12) s.sample = pick_level(LVL_ANY);
    else if (roll < 17) s.sample = pick_level(LVL_AT_UP);
    else if (roll < 22) s.sample = pick_level(LVL_AT_DOWN);
    else if (roll < 35) s.sample = pick_level(LVL_ABOVE_UP);
    else s.sample = pick_level(spiking_q[s.channel] ? LVL_BELOW_DOWN : LVL_ABOVE_UP);
    // time mostly moves forward; an occasional jump makes intervals wrap
    if ($urandom_range(0, 49) == 0) tick_q = $urandom();
    else tick_q = tick_q + $urandom_range(0, 60);
    s.timestamp = tick_q;
    prev_ch_q   = s.channel;
    send_sample(s);
    if (predict_spike(s, r)) expected_spikes = {expected_spikes, r};
  endtask

  // Result side: random stalls, one long hold-off on request, checking
  initial begin : result_sink
    int unsigned stall_left;
    spike_t      got;
    spike_t      want;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        got = spike_t'(m_axis_tdata[$bits(spike_t)-1:0]);
        if (expected_spikes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual channel %0d interval %0d",
                   $time, got.spike_channel, got.interval);
          mismatches++;
        end else begin
          want = expected_spikes.pop_front();
          if (got.spike_channel !== want.spike_channel) begin
            $display("%0t: spike_channel expected %0d actual %0d",
                     $time, want.spike_channel, got.spike_channel);
            mismatches++;
          end
          if (got.interval !== want.interval) begin
            $display("%0t: interval expected %0d actual %0d",
                     $time, want.interval, got.interval);
            mismatches++;
          end
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Ends the run when nothing transfers for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    row_t                    row;
    sample_t                 s;
    spike_t                  r;
    bit                      got;
    logic signed [THR_W-1:0] up_val;
    logic signed [THR_W-1:0] down_val;
    logic signed [THR_W-1:0] swap_val;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_UP_THR;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    up_thr_q   = UP_THR_RST;
    down_thr_q = DOWN_THR_RST;
    foreach (spiking_q[c]) begin
      spiking_q[c]   = 1'b0;
      last_time_q[c] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CFG) begin
        write_cfg(row.cfg_idx, row.value);
      end else begin
        s.channel   = row.channel;
        s.sample    = row.value;
        s.timestamp = row.timestamp;
        send_sample(s);
        got = predict_spike(s, r);
        case (row.kind)
          ROW_SPIKE: begin
            r.spike_channel = row.channel;
            r.interval      = row.interval;
            expected_spikes = {expected_spikes, r};
          end
          ROW_CHECKED: if (got) expected_spikes = {expected_spikes, r};
          default: ;
        endcase
      end
    end

    // Random phases, each with its own threshold pair
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin up_val = UP_THR_RST;   down_val = DOWN_THR_RST; end
        1: begin up_val = 16'sh7FFF;    down_val = 16'sh8000;    end
        2: begin up_val = 16'sh8000;    down_val = 16'sh8000;    end
        3: begin up_val = 16'sh8000;    down_val = 16'sh7FFF;    end
        4: begin up_val = '0;           down_val = '0;           end
        default: begin
          up_val   = THR_W'($urandom());
          down_val = THR_W'($urandom());
          // keep them ordered except in the last phase
          if (p < NUM_PHASES - 1 && up_val < down_val) begin
            swap_val = up_val;
            up_val   = down_val;
            down_val = swap_val;
          end
        end
      endcase
      write_cfg(CFG_UP_THR, up_val);
      write_cfg(CFG_DOWN_THR, down_val);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off with the sender pushing back to back
        if (p == 0 && n == 20) hold_off_req = 1'b1;
        gaps_on = (p % 3 != 2) && !(p == 0 && n >= 20 && n < 60);
        send_random();
      end
    end

    wait_idle();
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
